/* hw/rtl/hcp_pkg.sv */
// ---------------------------------------------------------------------------
// hcp_pkg
// Shared constants for the compass heading sentence parser: character codes,
// field widths and the fixed-point constant for the radian conversion.
// ---------------------------------------------------------------------------
package hcp_pkg;

    // sentence framing characters
    localparam logic [7:0] CH_START = 8'h24;  // '$'
    localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CH_END   = 8'h4E;  // 'N'
    localparam logic [7:0] CH_ABT_P = 8'h50;  // 'P'
    localparam logic [7:0] CH_ABT_O = 8'h4F;  // 'O'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'

    // default depth of the field byte store (legal range 3 to 15)
    localparam int FIELD_BYTES_DEF = 7;

    // result widths
    localparam int TENTHS_W = 17;
    localparam int RAD_W    = 24;

    // shared adder width: holds the signed digit sum for up to thirteen digits
    // and the full tenths * K product plus rounding bias
    localparam int ALU_W = 57;

    // bit position of the radian result inside the product
    localparam int RAD_LSB = 32;

    localparam logic [TENTHS_W-1:0] HEADING_MAX = 17'd99999;

    // round(pi * 2^48 / 1800)
    localparam logic [ALU_W-1:0] RAD_K = 57'd491266510558;

    // rounding bias for the final shift by 32
    localparam logic [ALU_W-1:0] RAD_BIAS = 57'h0000_0000_8000_0000;

endpackage

/* hw/rtl/hcp_alu.sv */
// ---------------------------------------------------------------------------
// hcp_alu
// Shared three-operand adder used for both the decimal digit accumulation
// and the shift-and-add multiply.
// ---------------------------------------------------------------------------
module hcp_alu
(
    input  logic [hcp_pkg::ALU_W-1:0] op_a,
    input  logic [hcp_pkg::ALU_W-1:0] op_b,
    input  logic [hcp_pkg::ALU_W-1:0] op_c,
    output logic [hcp_pkg::ALU_W-1:0] sum
);

    // two's complement sum, wraps at the adder width
    assign sum = op_a + op_b + op_c;

endmodule

/* hw/rtl/hcp_frame.sv */
// ---------------------------------------------------------------------------
// hcp_frame
// Sentence framing: hunts for the start character, skips the talker field,
// stores the heading field bytes and raises a conversion request on the
// end character when enough bytes are stored.
// ---------------------------------------------------------------------------
module hcp_frame
#(
    parameter int FIELD_BYTES = hcp_pkg::FIELD_BYTES_DEF,
    localparam int CNT_W = $clog2(FIELD_BYTES + 1),
    localparam int IDX_W = $clog2(FIELD_BYTES)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_acc,
    input  logic [7:0]       rx_byte,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [7:0]       rd_byte,
    output logic             conv_start,
    output logic [CNT_W-1:0] conv_count
);

    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_SKIP  = 2'd1;
    localparam logic [1:0] PH_STORE = 2'd2;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIELD_BYTES);
    localparam logic [CNT_W-1:0] CNT_MIN  = CNT_W'(3);

    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       bytes_reg [FIELD_BYTES];
    logic             wr_en;

    // phase and fill count update per accepted item
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        conv_start = 1'b0;
        if (byte_acc)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == hcp_pkg::CH_START)
                    begin
                        phase_next = PH_SKIP;
                        count_next = '0;
                    end
                end
                PH_SKIP:
                begin
                    if (rx_byte == hcp_pkg::CH_COMMA)
                    begin
                        phase_next = PH_STORE;
                        count_next = '0;
                    end
                end
                PH_STORE:
                begin
                    if (rx_byte == hcp_pkg::CH_END)
                    begin
                        conv_start = (count_reg >= CNT_MIN);
                        phase_next = PH_HUNT;
                        count_next = '0;
                    end
                    else if (rx_byte == hcp_pkg::CH_ABT_P || rx_byte == hcp_pkg::CH_ABT_O
                             || count_reg >= CNT_FULL)
                    begin
                        phase_next = PH_HUNT;
                        count_next = '0;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    count_next = '0;
                end
            endcase
        end
    end

    assign conv_count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // field byte store, written in order, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bytes_reg[count_reg[IDX_W-1:0]] <= rx_byte;
        end
    end

    assign rd_byte = bytes_reg[rd_idx];

endmodule

/* hw/rtl/hcp_conv.sv */
// ---------------------------------------------------------------------------
// hcp_conv
// Conversion sequencer: accumulates the decimal digits one per cycle,
// saturates the tenths value, then multiplies by the radian constant one
// multiplier bit per cycle, all through the shared adder.
// ---------------------------------------------------------------------------
module hcp_conv
#(
    parameter int FIELD_BYTES = hcp_pkg::FIELD_BYTES_DEF,
    localparam int CNT_W = $clog2(FIELD_BYTES + 1),
    localparam int IDX_W = $clog2(FIELD_BYTES)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         conv_start,
    input  logic [CNT_W-1:0]             conv_count,
    output logic [IDX_W-1:0]             rd_idx,
    input  logic [7:0]                   rd_byte,
    output logic                         busy,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [hcp_pkg::TENTHS_W-1:0] out_tenths,
    output logic [hcp_pkg::RAD_W-1:0]    out_rad
);

    localparam int ALU_W = hcp_pkg::ALU_W;
    localparam int TW    = hcp_pkg::TENTHS_W;
    localparam int BIT_W = $clog2(TW + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIG  = 3'd1;
    localparam logic [2:0] ST_SAT  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_HOLD = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [ALU_W-1:0] acc_reg;
    logic [ALU_W-1:0] acc_next;
    logic [ALU_W-1:0] mcand_reg;
    logic [ALU_W-1:0] mcand_next;
    logic [TW-1:0]    mplier_reg;
    logic [TW-1:0]    mplier_next;
    logic [TW-1:0]    tenths_reg;
    logic [TW-1:0]    tenths_next;
    logic [BIT_W-1:0] bit_reg;
    logic [BIT_W-1:0] bit_next;
    logic             ovld_reg;
    logic             ovld_next;
    logic [TW-1:0]    otenths_reg;
    logic [TW-1:0]    otenths_next;
    logic [hcp_pkg::RAD_W-1:0] orad_reg;
    logic [hcp_pkg::RAD_W-1:0] orad_next;

    logic [ALU_W-1:0] op_a;
    logic [ALU_W-1:0] op_b;
    logic [ALU_W-1:0] op_c;
    logic [ALU_W-1:0] alu_sum;
    logic [8:0]       digit;
    logic [IDX_W-1:0] tenths_idx;
    logic [IDX_W-1:0] last_int_idx;
    logic [IDX_W-1:0] start_idx;
    logic [CNT_W-1:0] cnt_m2;
    logic [CNT_W-1:0] cnt_m4;
    logic [CNT_W-1:0] start_m2;

    hcp_alu u_alu
    (
        .op_a (op_a),
        .op_b (op_b),
        .op_c (op_c),
        .sum  (alu_sum)
    );

    // positions of the tenths digit and the last integer digit
    assign cnt_m2       = cnt_reg - CNT_W'(2);
    assign cnt_m4       = cnt_reg - CNT_W'(4);
    assign tenths_idx   = cnt_m2[IDX_W-1:0];
    assign last_int_idx = cnt_m4[IDX_W-1:0];
    assign start_m2     = conv_count - CNT_W'(2);
    assign start_idx    = (conv_count == CNT_W'(3)) ? start_m2[IDX_W-1:0] : '0;

    // signed digit value, byte minus '0'
    assign digit = {1'b0, rd_byte} - {1'b0, hcp_pkg::CH_ZERO};

    // operand selection for the shared adder
    always_comb
    begin
        if (state_reg == ST_DIG)
        begin
            op_a = {acc_reg[ALU_W-4:0], 3'b000};
            op_b = {acc_reg[ALU_W-2:0], 1'b0};
            op_c = {{(ALU_W-9){digit[8]}}, digit};
        end
        else
        begin
            op_a = acc_reg;
            op_b = mplier_reg[0] ? mcand_reg : '0;
            op_c = '0;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        tenths_next  = tenths_reg;
        bit_next     = bit_reg;
        ovld_next    = ovld_reg && !out_ready;
        otenths_next = otenths_reg;
        orad_next    = orad_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (conv_start)
                begin
                    cnt_next   = conv_count;
                    idx_next   = start_idx;
                    acc_next   = '0;
                    state_next = ST_DIG;
                end
            end
            ST_DIG:
            begin
                acc_next = alu_sum;
                if (idx_reg == tenths_idx)
                begin
                    state_next = ST_SAT;
                end
                else if (idx_reg == last_int_idx)
                begin
                    idx_next = tenths_idx;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_SAT:
            begin
                if (acc_reg[ALU_W-1])
                begin
                    tenths_next = '0;
                end
                else if (acc_reg > {{(ALU_W-TW){1'b0}}, hcp_pkg::HEADING_MAX})
                begin
                    tenths_next = hcp_pkg::HEADING_MAX;
                end
                else
                begin
                    tenths_next = acc_reg[TW-1:0];
                end
                mplier_next = tenths_next;
                mcand_next  = hcp_pkg::RAD_K;
                acc_next    = hcp_pkg::RAD_BIAS;
                bit_next    = BIT_W'(TW);
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                acc_next    = alu_sum;
                mcand_next  = {mcand_reg[ALU_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[TW-1:1]};
                bit_next    = bit_reg - BIT_W'(1);
                if (bit_reg == BIT_W'(1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!ovld_reg || out_ready)
                begin
                    ovld_next    = 1'b1;
                    otenths_next = tenths_reg;
                    orad_next    = acc_reg[hcp_pkg::RAD_LSB +: hcp_pkg::RAD_W];
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovld_reg  <= ovld_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        idx_reg     <= idx_next;
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        tenths_reg  <= tenths_next;
        bit_reg     <= bit_next;
        otenths_reg <= otenths_next;
        orad_reg    <= orad_next;
    end

    assign rd_idx     = idx_reg;
    assign busy       = (state_reg != ST_IDLE);
    assign out_valid  = ovld_reg;
    assign out_tenths = otenths_reg;
    assign out_rad    = orad_reg;

endmodule

/* hw/rtl/compass_heading_sentence_parser.sv */
// ---------------------------------------------------------------------------
// compass_heading_sentence_parser
// Conversion: after the end character the integer digits and the tenths digit
//   are accumulated, the tenths value is saturated, the product with the
//   radian constant is formed and the result is loaded into the output register.
// Throughput: one byte per cycle, none taken while a conversion runs; a held
//   result stalls input only once the next conversion has finished.
// Reset: asynchronous active low, returns to start-character hunt, no output.
// ---------------------------------------------------------------------------
module compass_heading_sentence_parser
#(
    parameter int FIELD_BYTES = hcp_pkg::FIELD_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [16:0] heading_tenths, [40:17] heading_rad_q16
);

    localparam int CNT_W = $clog2(FIELD_BYTES + 1);
    localparam int IDX_W = $clog2(FIELD_BYTES);

    logic                         byte_acc;
    logic                         conv_start;
    logic [CNT_W-1:0]             conv_count;
    logic [IDX_W-1:0]             rd_idx;
    logic [7:0]                   rd_byte;
    logic                         busy;
    logic [hcp_pkg::TENTHS_W-1:0] out_tenths;
    logic [hcp_pkg::RAD_W-1:0]    out_rad;

    assign s_tready = !busy;
    assign byte_acc = s_tvalid && s_tready;

    // sentence framing and field store
    hcp_frame #(.FIELD_BYTES(FIELD_BYTES)) u_frame
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_acc   (byte_acc),
        .rx_byte    (s_tdata),
        .rd_idx     (rd_idx),
        .rd_byte    (rd_byte),
        .conv_start (conv_start),
        .conv_count (conv_count)
    );

    // digit conversion and radian scaling
    hcp_conv #(.FIELD_BYTES(FIELD_BYTES)) u_conv
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .conv_start (conv_start),
        .conv_count (conv_count),
        .rd_idx     (rd_idx),
        .rd_byte    (rd_byte),
        .busy       (busy),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_tenths (out_tenths),
        .out_rad    (out_rad)
    );

    // result packing, zero filled to whole bytes
    assign m_tdata = {7'd0, out_rad, out_tenths};

endmodule

/* sim/tb_compass_heading_sentence_parser.sv */
// ---------------------------------------------------------------------------
// tb_compass_heading_sentence_parser
// Streams serial characters into the heading parser and checks every heading
// it returns. A behavioral copy of the sentence framing and the digit
// conversion runs on each accepted character and queues the heading that the
// block must produce, which the output monitor compares field by field.
// ---------------------------------------------------------------------------
module tb_compass_heading_sentence_parser;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIELD_DEPTH = hcp_pkg::FIELD_BYTES_DEF;
    localparam int CHAR_TARGET = 1400;
    localparam int DRAIN_CYCLES = 40;
    localparam longint unsigned PI_Q48 = 64'h3243F6A8885A3;
    localparam longint unsigned RAD_SCALE = (PI_Q48 + 64'd900) / 64'd1800;
    localparam longint HEADING_LIMIT = 99999;

    typedef enum logic [1:0] {HUNT_START, SKIP_HEADER, COLLECT_FIELD} parse_phase_t;
    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SLOW} rx_mode_t;

    typedef struct {
        logic [hcp_pkg::TENTHS_W-1:0] tenths;
        logic [hcp_pkg::RAD_W-1:0]    rad;
    } heading_t;

    typedef struct {
        logic [7:0] rx_char;
        bit         wait_idle;
    } tx_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    tx_item_t    char_queue[$];
    heading_t    heading_due[$];
    int          sent_chars = 0;
    int          err_count = 0;
    logic        char_taken = 1'b0;
    int          burst_left = 1;
    int          gap_left = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_mode_left = 0;

    // shadow of the parser state
    parse_phase_t parse_phase = HUNT_START;
    logic [7:0]   field_store [FIELD_DEPTH];
    int           field_count = 0;

    compass_heading_sentence_parser uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] rx_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [16:0] heading_tenths, [40:17] heading_rad_q16
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic longint digit_of(input logic [7:0] c);
        return longint'(c) - longint'(hcp_pkg::CH_ZERO);
    endfunction

    // integer digits, skip the separator, then the tenths digit
    function automatic heading_t convert_field();
        longint            acc;
        longint unsigned   scaled;
        heading_t          h;
        acc = 0;
        for (int i = 0; i < field_count - 3; i++)
        begin
            acc = acc * 10 + digit_of(field_store[i]);
        end
        acc = acc * 10 + digit_of(field_store[field_count - 2]);
        if (acc < 0)
            acc = 0;
        if (acc > HEADING_LIMIT)
            acc = HEADING_LIMIT;
        scaled = longint'(acc) * RAD_SCALE + 64'h8000_0000;
        h.tenths = acc[hcp_pkg::TENTHS_W-1:0];
        h.rad = scaled[hcp_pkg::RAD_LSB +: hcp_pkg::RAD_W];
        return h;
    endfunction

    // advance the shadow parser by one accepted character
    function automatic void track_char(input logic [7:0] c);
        case (parse_phase)
            HUNT_START:
            begin
                if (c == hcp_pkg::CH_START)
                begin
                    parse_phase = SKIP_HEADER;
                    field_count = 0;
                end
            end
            SKIP_HEADER:
            begin
                if (c == hcp_pkg::CH_COMMA)
                begin
                    parse_phase = COLLECT_FIELD;
                    field_count = 0;
                end
            end
            default:
            begin
                if (c == hcp_pkg::CH_END)
                begin
                    if (field_count >= 3)
                        heading_due.push_back(convert_field());
                    parse_phase = HUNT_START;
                    field_count = 0;
                end
                else if (c == hcp_pkg::CH_ABT_P || c == hcp_pkg::CH_ABT_O
                         || field_count >= FIELD_DEPTH)
                begin
                    parse_phase = HUNT_START;
                    field_count = 0;
                end
                else
                begin
                    field_store[field_count] = c;
                    field_count++;
                end
            end
        endcase
    endfunction

    // input tracking and output checking at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_taken <= 1'b0;
        end
        else
        begin
            char_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                if (heading_due.size() == 0)
                begin
                    report_mismatch("unexpected heading, tenths",
                                    longint'(m_tdata[16:0]), -1);
                end
                else
                begin
                    heading_t want;
                    want = heading_due.pop_front();
                    if (m_tdata[16:0] !== want.tenths)
                        report_mismatch("heading_tenths", longint'(m_tdata[16:0]),
                                        longint'(want.tenths));
                    if (m_tdata[40:17] !== want.rad)
                        report_mismatch("heading_rad_q16", longint'(m_tdata[40:17]),
                                        longint'(want.rad));
                    if (m_tdata[47:41] !== 7'd0)
                        report_mismatch("tdata padding", longint'(m_tdata[47:41]), 0);
                end
            end
            if (s_tvalid && s_tready)
                track_char(s_tdata);
        end
    end

    // character driver: bursts with random gaps, optional wait for idle
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (s_tvalid && !char_taken)
        begin
            s_tvalid <= 1'b1;
        end
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            s_tvalid <= 1'b0;
        end
        else if (char_queue.size() == 0)
        begin
            s_tvalid <= 1'b0;
        end
        else if (char_queue[0].wait_idle && heading_due.size() != 0)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            tx_item_t next_item;
            next_item = char_queue.pop_front();
            s_tdata <= next_item.rx_char;
            s_tvalid <= 1'b1;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 24);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            else
            begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // result receiver: switches between open, random and slow stretches
    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 2));
            rx_mode_left <= $urandom_range(20, 300);
        end
        else
        begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
            default:   m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic push_char(input logic [7:0] c, input bit wait_idle);
        tx_item_t t;
        t.rx_char = c;
        t.wait_idle = wait_idle;
        char_queue.push_back(t);
        sent_chars++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_char(s[i], 1'b0);
        end
    endtask

    task automatic push_digits(input int count);
        for (int i = 0; i < count; i++)
        begin
            push_char(8'(hcp_pkg::CH_ZERO + $urandom_range(0, 9)), 1'b0);
        end
    endtask

    // one random sentence, mostly well formed
    task automatic add_random_sentence(input bit wait_idle);
        int kind;
        int count;
        logic [7:0] fill;
        if ($urandom_range(0, 3) == 0)
        begin
            count = $urandom_range(1, 3);
            for (int i = 0; i < count; i++)
                push_char(8'($urandom_range(0, 255)), 1'b0);
        end
        push_char(hcp_pkg::CH_START, wait_idle);
        count = $urandom_range(0, 5);
        for (int i = 0; i < count; i++)
        begin
            push_char(8'(($urandom_range(0, 9) == 0) ? hcp_pkg::CH_START
                                                     : 8'h41 + $urandom_range(0, 25)),
                      1'b0);
        end
        push_char(hcp_pkg::CH_COMMA, 1'b0);
        kind = $urandom_range(0, 99);
        if (kind < 65)
        begin
            // well formed heading with 0 to 4 integer digits
            push_digits($urandom_range(0, FIELD_DEPTH - 3));
            push_char(8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : 8'h2E), 1'b0);
            push_digits(1);
            push_char(hcp_pkg::CH_COMMA, 1'b0);
            push_char(hcp_pkg::CH_END, 1'b0);
        end
        else if (kind < 75)
        begin
            // arbitrary field content
            count = $urandom_range(0, FIELD_DEPTH + 1);
            for (int i = 0; i < count; i++)
                push_char(8'($urandom_range(0, 255)), 1'b0);
            push_char(hcp_pkg::CH_END, 1'b0);
        end
        else if (kind < 82)
        begin
            // too short for a heading
            push_digits($urandom_range(0, 2));
            push_char(hcp_pkg::CH_END, 1'b0);
        end
        else if (kind < 90)
        begin
            // aborted sentence, trailing characters land in the hunt
            push_digits($urandom_range(0, FIELD_DEPTH - 1));
            push_char(($urandom_range(0, 1) == 0) ? hcp_pkg::CH_ABT_P : hcp_pkg::CH_ABT_O,
                      1'b0);
            push_digits($urandom_range(0, 3));
            push_char(hcp_pkg::CH_END, 1'b0);
        end
        else if (kind < 95)
        begin
            // field longer than the store
            push_digits($urandom_range(FIELD_DEPTH + 1, FIELD_DEPTH + 2));
            push_char(hcp_pkg::CH_END, 1'b0);
        end
        else
        begin
            // largest or smallest heading
            fill = ($urandom_range(0, 1) == 0) ? hcp_pkg::CH_ZERO : hcp_pkg::CH_ZERO + 8'd9;
            for (int i = 0; i < FIELD_DEPTH - 3; i++)
                push_char(fill, 1'b0);
            push_char(8'h2E, 1'b0);
            push_char(fill, 1'b0);
            push_char(hcp_pkg::CH_COMMA, 1'b0);
            push_char(hcp_pkg::CH_END, 1'b0);
        end
    endtask

    initial
    begin
        int sentence_no;

        // directed sentences
        push_text("$,9999.9,N");
        push_text("$$,.5,N");
        push_text("$,");
        for (int i = 0; i < 4; i++)
            push_char(8'hFF, 1'b0);
        push_char(8'h2E, 1'b0);
        push_char(8'hFF, 1'b0);
        push_text(",N");
        push_text("$,$,1.2,N");
        push_char(8'h00, 1'b0);
        push_text("$,1,N");
        push_text("$,3P$,1O");
        push_text("$,1234567XN");

        // random sentences
        sentence_no = 0;
        while (sent_chars < CHAR_TARGET)
        begin
            add_random_sentence(sentence_no % 25 == 0);
            sentence_no++;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (char_queue.size() != 0 || s_tvalid)
            @(posedge clk);
        while (heading_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
